// ===== hw/rtl/zero_doppler_notch_peak_detect_macros.svh =====
// assertion macros for the zero-Doppler notch peak detector
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef ZERO_DOPPLER_NOTCH_PEAK_DETECT_MACROS_SVH
`define ZERO_DOPPLER_NOTCH_PEAK_DETECT_MACROS_SVH

// same-cycle implication
`define ZDN_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("zdn same-cycle check failed");

// next-cycle implication
`define ZDN_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("zdn next-cycle check failed");

`endif

// ===== hw/rtl/zdn_pkg.sv =====
// shared constants and types for the zero-Doppler notch peak detector
// no dependencies
`default_nettype none

package zdn_pkg;

    localparam int DOPPLER_ROWS = 64;
    localparam int RANGE_BINS   = 256;
    localparam int FRAME_BINS   = DOPPLER_ROWS * RANGE_BINS;

    localparam int POS_W  = $clog2(FRAME_BINS);
    localparam int COL_W  = $clog2(RANGE_BINS);
    localparam int ROW_W  = $clog2(DOPPLER_ROWS);
    localparam int FILL_W = $clog2(FRAME_BINS + 1);

    localparam int MAG_W       = 16;
    localparam int CFG_W       = 6;
    localparam int RISE_W      = 17;
    localparam int BIN_OUT_W   = 14;
    localparam int RANGE_OUT_W = 8;
    localparam int ROW_OUT_W   = 6;
    localparam int CMP_W       = (ROW_W > CFG_W) ? ROW_W : CFG_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_NOTCH_FIRST = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NOTCH_LAST  = 1'b1;

    localparam logic [CFG_W-1:0] NOTCH_FIRST_RESET = 6'd32;
    localparam logic [CFG_W-1:0] NOTCH_LAST_RESET  = 6'd33;

    typedef struct packed {
        logic [CFG_W-1:0] first_row;
        logic [CFG_W-1:0] last_row;
    } t_notch_cfg;

    // stage-one item handed from the front end to the peak tracker
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             first;
        logic             prev_ok;
        logic [MAG_W-1:0] notched;
        logic [MAG_W-1:0] prev;
        logic [POS_W-1:0] pos;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_s1;

endpackage

`default_nettype wire

// ===== hw/rtl/zero_doppler_notch_peak_detect.sv =====
// top level of the zero-Doppler notch peak detector
// depends on zdn_pkg, zdn_cfg_regs, zdn_bin_front, zdn_peak_track and the macros header
//
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------------
// s_axis    | in        | tvalid/tready          | tdata magnitude, tlast last bin of frame
// m_axis    | out       | tvalid/tready          | tdata notched/bin/range/row/rise, tuser det
// apb       | in        | psel/penable, pready=1 | notch_first_row @0x0, notch_last_row @0x4
//
// one item per cycle sustained while m_axis is not stalled; an accepted item passes the stage-one
// register (with the store read register), then the output register
// the previous-frame store is one read-first memory port, read and written once per item
// reset clears counters, winner and a fill mark; unwritten store entries read as zero
// through the fill mark, so there is no clearing pass and items are taken right after reset
// a stalled output holds its item; the front keeps taking items until both stages are full
`default_nettype none

module zero_doppler_notch_peak_detect (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // [15:0] magnitude
    input  wire logic [15:0]                     s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] notched_magnitude, [29:16] detected_bin, [37:30] range index,
    // [43:38] doppler_row, [60:44] peak_rise, [63:61] zero
    output logic      [63:0]                     m_axis_tdata,
    // [0] detect_valid
    output logic      [0:0]                      m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [zdn_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [zdn_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [zdn_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

`include "zero_doppler_notch_peak_detect_macros.svh"

    zdn_pkg::t_notch_cfg                       w_cfg;
    zdn_pkg::t_s1                              w_s1;
    logic                                      w_advance;
    logic        [zdn_pkg::MAG_W-1:0]          w_notched;
    logic                                      w_detect;
    logic        [zdn_pkg::BIN_OUT_W-1:0]      w_bin;
    logic        [zdn_pkg::RANGE_OUT_W-1:0]    w_range;
    logic        [zdn_pkg::ROW_OUT_W-1:0]      w_row;
    logic signed [zdn_pkg::RISE_W-1:0]         w_rise;

    zdn_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    zdn_bin_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (s_axis_tvalid),
        .i_magnitude (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_advance   (w_advance),
        .o_in_ready  (s_axis_tready),
        .o_s1        (w_s1)
    );

    zdn_peak_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (w_s1),
        .i_out_ready (m_axis_tready),
        .o_advance   (w_advance),
        .o_out_valid (m_axis_tvalid),
        .o_notched   (w_notched),
        .o_detect    (w_detect),
        .o_bin       (w_bin),
        .o_range     (w_range),
        .o_row       (w_row),
        .o_rise      (w_rise)
    );

    assign m_axis_tdata = {3'b000, w_rise, w_row, w_range, w_bin, w_notched};
    assign m_axis_tuser = w_detect;

    // detection fields are zero on every result but the last bin's
    `ZDN_ASSERT_SAME(a_detect_fields_zero, m_axis_tvalid && !w_detect, m_axis_tdata[60:16] == '0)
    // input back-pressure only when both stages hold an item and the output is stalled
    `ZDN_ASSERT_SAME(a_stall_full, !s_axis_tready, w_s1.valid && m_axis_tvalid && !m_axis_tready)
    // an accepted item always lands in stage one
    `ZDN_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, w_s1.valid)

endmodule

`default_nettype wire

// ===== hw/rtl/zdn_cfg_regs.sv =====
// APB register file holding the notch band limits
// depends on zdn_pkg
`default_nettype none

module zdn_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [zdn_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [zdn_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [zdn_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output zdn_pkg::t_notch_cfg                  o_cfg
);

    logic [zdn_pkg::CFG_W-1:0]     r_first;
    logic [zdn_pkg::CFG_W-1:0]     r_last;
    logic [zdn_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[2 +: zdn_pkg::REG_IDX_W];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= zdn_pkg::NOTCH_FIRST_RESET;
            r_last  <= zdn_pkg::NOTCH_LAST_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                zdn_pkg::REG_NOTCH_FIRST: r_first <= pwdata[zdn_pkg::CFG_W-1:0];
                zdn_pkg::REG_NOTCH_LAST:  r_last  <= pwdata[zdn_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            zdn_pkg::REG_NOTCH_FIRST: prdata[zdn_pkg::CFG_W-1:0] = r_first;
            zdn_pkg::REG_NOTCH_LAST:  prdata[zdn_pkg::CFG_W-1:0] = r_last;
            default: ;
        endcase
    end

    assign o_cfg.first_row = r_first;
    assign o_cfg.last_row  = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/zdn_bin_front.sv =====
// front end: bin position counters, notch, previous-frame store and stage-one register
// depends on zdn_pkg
`default_nettype none

module zdn_bin_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire zdn_pkg::t_notch_cfg         i_cfg,
    input  wire logic                        i_in_valid,
    input  wire logic [zdn_pkg::MAG_W-1:0]   i_magnitude,
    input  wire logic                        i_last,
    input  wire logic                        i_advance,
    output logic                             o_in_ready,
    output zdn_pkg::t_s1                     o_s1
);

    logic [zdn_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [zdn_pkg::ROW_W-1:0]  r_row, n_row;
    logic [zdn_pkg::COL_W-1:0]  r_col, n_col;
    logic [zdn_pkg::FILL_W-1:0] r_fill;

    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic                       r_s1_first;
    logic                       r_s1_prev_ok;
    logic [zdn_pkg::MAG_W-1:0]  r_s1_notched;
    logic [zdn_pkg::POS_W-1:0]  r_s1_pos;
    logic [zdn_pkg::ROW_W-1:0]  r_s1_row;
    logic [zdn_pkg::COL_W-1:0]  r_s1_col;
    logic [zdn_pkg::MAG_W-1:0]  r_rd;

    logic [zdn_pkg::MAG_W-1:0]  r_mem [zdn_pkg::FRAME_BINS];

    logic                       w_accept;
    logic                       w_in_band;
    logic [zdn_pkg::CMP_W-1:0]  w_row_cmp;
    logic [zdn_pkg::MAG_W-1:0]  w_notched;
    logic                       w_written;

    // no item is taken while reset is held
    assign o_in_ready = i_rst_n & (~r_s1_valid | i_advance);
    assign w_accept   = i_in_valid & o_in_ready;

    assign w_row_cmp = zdn_pkg::CMP_W'(r_row);
    assign w_in_band = (w_row_cmp >= zdn_pkg::CMP_W'(i_cfg.first_row)) &&
                       (w_row_cmp <= zdn_pkg::CMP_W'(i_cfg.last_row));
    assign w_notched = w_in_band ? '0 : i_magnitude;

    // the store is only ever written as a prefix from bin zero, so a fill mark stands in for reset
    assign w_written = zdn_pkg::FILL_W'(r_pos) < r_fill;

    always_comb begin
        n_pos = r_pos + zdn_pkg::POS_W'(1);
        n_row = r_row;
        n_col = r_col + zdn_pkg::COL_W'(1);
        if (r_col == zdn_pkg::COL_W'(zdn_pkg::RANGE_BINS - 1)) begin
            n_col = '0;
            n_row = r_row + zdn_pkg::ROW_W'(1);
        end
        if (i_last || (r_pos == zdn_pkg::POS_W'(zdn_pkg::FRAME_BINS - 1))) begin
            n_pos = '0;
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            r_pos <= n_pos;
            r_row <= n_row;
            r_col <= n_col;
            if (!w_written) begin
                r_fill <= r_fill + zdn_pkg::FILL_W'(1);
            end
        end
    end

    // read-first: the old entry comes back while the notched value goes in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd         <= r_mem[r_pos];
            r_mem[r_pos] <= w_notched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last    <= i_last;
            r_s1_first   <= (r_pos == '0);
            r_s1_prev_ok <= w_written;
            r_s1_notched <= w_notched;
            r_s1_pos     <= r_pos;
            r_s1_row     <= r_row;
            r_s1_col     <= r_col;
        end
    end

    assign o_s1.valid   = r_s1_valid;
    assign o_s1.last    = r_s1_last;
    assign o_s1.first   = r_s1_first;
    assign o_s1.prev_ok = r_s1_prev_ok;
    assign o_s1.notched = r_s1_notched;
    assign o_s1.prev    = r_rd;
    assign o_s1.pos     = r_s1_pos;
    assign o_s1.row     = r_s1_row;
    assign o_s1.col     = r_s1_col;

endmodule

`default_nettype wire

// ===== hw/rtl/zdn_peak_track.sv =====
// rise computation, running winner and output register
// depends on zdn_pkg
`default_nettype none

module zdn_peak_track (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire zdn_pkg::t_s1                         i_s1,
    input  wire logic                                 i_out_ready,
    output logic                                      o_advance,
    output logic                                      o_out_valid,
    output logic        [zdn_pkg::MAG_W-1:0]          o_notched,
    output logic                                      o_detect,
    output logic        [zdn_pkg::BIN_OUT_W-1:0]      o_bin,
    output logic        [zdn_pkg::RANGE_OUT_W-1:0]    o_range,
    output logic        [zdn_pkg::ROW_OUT_W-1:0]      o_row,
    output logic signed [zdn_pkg::RISE_W-1:0]         o_rise
);

    logic signed [zdn_pkg::RISE_W-1:0] r_best_rise, n_best_rise;
    logic        [zdn_pkg::POS_W-1:0]  r_best_pos,  n_best_pos;
    logic        [zdn_pkg::ROW_W-1:0]  r_best_row,  n_best_row;
    logic        [zdn_pkg::COL_W-1:0]  r_best_col,  n_best_col;
    logic                              r_out_valid;

    logic        [zdn_pkg::MAG_W-1:0]  w_prev;
    logic signed [zdn_pkg::RISE_W-1:0] w_rise;
    logic                              w_take;

    assign o_advance = i_s1.valid & (~r_out_valid | i_out_ready);

    assign w_prev = i_s1.prev_ok ? i_s1.prev : '0;
    assign w_rise = $signed({1'b0, i_s1.notched}) - $signed({1'b0, w_prev});
    // first bin of a frame wins outright; later bins need a strict rise to keep the first on ties
    assign w_take = i_s1.first || (w_rise > r_best_rise);

    always_comb begin
        n_best_rise = r_best_rise;
        n_best_pos  = r_best_pos;
        n_best_row  = r_best_row;
        n_best_col  = r_best_col;
        if (w_take) begin
            n_best_rise = w_rise;
            n_best_pos  = i_s1.pos;
            n_best_row  = i_s1.row;
            n_best_col  = i_s1.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_rise <= '0;
            r_best_pos  <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (o_advance) begin
            if (i_s1.last) begin
                r_best_rise <= '0;
                r_best_pos  <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_best_rise <= n_best_rise;
                r_best_pos  <= n_best_pos;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            o_notched <= i_s1.notched;
            o_detect  <= i_s1.last;
            if (i_s1.last) begin
                o_bin   <= zdn_pkg::BIN_OUT_W'(n_best_pos);
                o_range <= zdn_pkg::RANGE_OUT_W'(n_best_col);
                o_row   <= zdn_pkg::ROW_OUT_W'(n_best_row);
                o_rise  <= n_best_rise;
            end else begin
                o_bin   <= '0;
                o_range <= '0;
                o_row   <= '0;
                o_rise  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for zero_doppler_notch_peak_detect
// drives bins on the slave stream, checks each result against an in-bench predictor
// depends on zdn_pkg and the rtl top level only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zdn_pkg::*;

    typedef struct packed {
        logic [15:0] magnitude;
        logic        last;
    } bin_item_t;

    typedef struct packed {
        logic [15:0] notched;
        logic        detect;
        logic [13:0] bin;
        logic [7:0]  range_idx;
        logic [5:0]  row;
        logic [16:0] rise;
    } detection_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [15:0]           s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    zero_doppler_notch_peak_detect u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [CFG_W-1:0] notch_first = NOTCH_FIRST_RESET;
    logic [CFG_W-1:0] notch_last  = NOTCH_LAST_RESET;
    logic [15:0]      prev_frame [FRAME_BINS] = '{default: '0};
    int unsigned      bin_pos = 0;
    int               best_rise = 0;
    int unsigned      best_bin = 0;

    bin_item_t  pending_bins [$];
    detection_t expected_detections [$];
    int         mismatch_count = 0;

    // notch, frame difference against the stored frame, running argmax
    function automatic detection_t predict_bin(input bin_item_t item);
        detection_t  r;
        int unsigned row;
        int          diff;
        r = '0;
        row = bin_pos / RANGE_BINS;
        r.notched = (row >= notch_first && row <= notch_last) ? 16'h0000 : item.magnitude;
        diff = int'(r.notched) - int'(prev_frame[bin_pos]);
        prev_frame[bin_pos] = r.notched;
        // first bin of a frame wins unconditionally, ties keep the earlier bin
        if (bin_pos == 0 || diff > best_rise) begin
            best_rise = diff;
            best_bin = bin_pos;
        end
        if (item.last) begin
            r.detect = 1'b1;
            r.bin = 14'(best_bin);
            r.range_idx = 8'(best_bin % RANGE_BINS);
            r.row = 6'(best_bin / RANGE_BINS);
            r.rise = 17'(best_rise);
            bin_pos = 0;
            best_rise = 0;
            best_bin = 0;
        end else begin
            bin_pos = (bin_pos + 1) % FRAME_BINS;
        end
        return r;
    endfunction

    function automatic logic [15:0] random_magnitude();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    // mostly rows near the start of the frame, where short frames live
    function automatic logic [31:0] random_notch_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0: w[5:0] = 6'($urandom_range(0, 63));
            1: w[5:0] = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
            default: w[5:0] = 6'($urandom_range(0, 3));
        endcase
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic push_bin(input logic [15:0] magnitude, input logic last);
        bin_item_t item;
        item.magnitude = magnitude;
        item.last = last;
        pending_bins.insert(pending_bins.size(), item);
    endtask

    task automatic wait_idle();
        while (pending_bins.size() != 0 || s_axis_tvalid || expected_detections.size() != 0)
            @(posedge i_clk);
    endtask

    // write one notch register, then read it back
    task automatic write_notch_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_NOTCH_FIRST) notch_first = value[CFG_W-1:0];
        else notch_last = value[CFG_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", {26'b0, value[CFG_W-1:0]}, readback);
    endtask

    // sender: bursts of random length with random gaps
    bin_item_t offered;
    int        burst_left = 1;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_detections.insert(expected_detections.size(), predict_bin(offered));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || pending_bins.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    offered = pending_bins.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= offered.magnitude;
                    s_axis_tlast <= offered.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a periodic long hold-off
    int unsigned rx_cycle = 0;
    int          long_hold_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (long_hold_left > 0) begin
            long_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_cycle % 600 == 400) begin
            long_hold_left = 80;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_cycle % 3 != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        detection_t got;
        detection_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.notched = m_axis_tdata[15:0];
            got.bin = m_axis_tdata[29:16];
            got.range_idx = m_axis_tdata[37:30];
            got.row = m_axis_tdata[43:38];
            got.rise = m_axis_tdata[60:44];
            got.detect = m_axis_tuser[0];
            if (expected_detections.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tdata %h tuser %h",
                         $realtime, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_detections.pop_front();
                check_field("notched_magnitude", 32'(want.notched), 32'(got.notched));
                check_field("detect_valid", 32'(want.detect), 32'(got.detect));
                check_field("detected_bin", 32'(want.bin), 32'(got.bin));
                check_field("range index", 32'(want.range_idx), 32'(got.range_idx));
                check_field("doppler_row", 32'(want.row), 32'(got.row));
                check_field("peak_rise", 32'(want.rise), 32'(got.rise));
            end
        end
    end

    initial begin
        int  queued;
        int  frame_len;
        bit  paused;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset notch band; first frame against an empty store
        push_bin(16'hFFFF, 1'b1);
        push_bin(16'h0000, 1'b1);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h8000, 1'b0);
        push_bin(16'h8000, 1'b1);
        // falling frame still reports its largest rise, which is negative
        push_bin(16'h0010, 1'b0);
        push_bin(16'h0020, 1'b0);
        push_bin(16'h0008, 1'b1);
        // equal rises everywhere, earliest bin wins
        push_bin(16'h0020, 1'b0);
        push_bin(16'h0030, 1'b0);
        push_bin(16'h0018, 1'b0);
        push_bin(16'h0010, 1'b1);
        wait_idle();

        // notch on row zero, upper write bits set
        write_notch_reg(REG_NOTCH_FIRST, 32'hFFFF_FFC0);
        write_notch_reg(REG_NOTCH_LAST, 32'hAAAA_AA80);
        push_bin(16'h1234, 1'b0);
        push_bin(16'hFFFF, 1'b1);
        wait_idle();

        // empty band
        write_notch_reg(REG_NOTCH_FIRST, 32'd1);
        push_bin(16'hABCD, 1'b0);
        push_bin(16'h5432, 1'b1);
        wait_idle();

        // whole frame notched
        write_notch_reg(REG_NOTCH_FIRST, 32'd0);
        write_notch_reg(REG_NOTCH_LAST, 32'd63);
        push_bin(16'h7777, 1'b0);
        push_bin(16'h0001, 1'b1);
        wait_idle();

        // random short frames under random notch bands
        paused = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            write_notch_reg(REG_NOTCH_FIRST, random_notch_word());
            write_notch_reg(REG_NOTCH_LAST, random_notch_word());
            queued = 0;
            while (queued < 300) begin
                if (ph == 1 && queued >= 150 && !paused) begin
                    wait_idle();
                    paused = 1'b1;
                end
                case ($urandom_range(0, 19))
                    0: frame_len = $urandom_range(257, 800);
                    1, 2, 3, 4, 5: frame_len = $urandom_range(41, 256);
                    default: frame_len = $urandom_range(1, 40);
                endcase
                for (int i = 0; i < frame_len; i++)
                    push_bin(random_magnitude(), i == frame_len - 1);
                queued += frame_len;
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("zero_doppler_notch_peak_detect: match");
        end else begin
            $display("zero_doppler_notch_peak_detect: mismatch");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("zero_doppler_notch_peak_detect: mismatch");
        $finish;
    end

endmodule
